@@ hw/rtl/ermg_pkg.sv @@
// ermg_pkg: shared constants, types and tables for the euler rotation matrix generator
// no dependencies
`default_nettype none
package ermg_pkg;

  localparam int ANGLE_BITS_DEF        = 16;
  localparam int ELEMENT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF     = 16;

  localparam int CORDIC_FRAC = 30;
  localparam int PHASE_W     = 32;
  // datapath width for cordic x/y: Q30 with headroom
  localparam int XY_W        = 33;
  localparam int Z_W         = 34;
  localparam int ELEM_W      = 16;
  localparam int CUTOFF_W    = 8;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // rotation order codes
  localparam logic [2:0] OP_X  = 3'd0;
  localparam logic [2:0] OP_Y  = 3'd1;
  localparam logic [2:0] OP_Z  = 3'd2;
  localparam logic [2:0] OP_XZ = 3'd3;
  localparam logic [2:0] OP_YX = 3'd4;
  localparam logic [2:0] OP_ZY = 3'd5;

  // arctangent table, 31 steps, full turn scaled to 2^32
  function automatic logic signed [Z_W-1:0] atan_tab(input int i);
    logic signed [Z_W-1:0] t;
    case (i)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;    4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;     10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;      16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;       19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;        22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;         25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;          28: t = 34'sd3;         29: t = 34'sd1;
      30: t = 34'sd1;          default: t = '0;
    endcase
    return t;
  endfunction

  // one pipeline slot of cordic state
  typedef struct packed {
    logic                   vld;
    logic [2:0]             op;
    logic                   flip_a;
    logic                   flip_b;
    logic signed [XY_W-1:0] xa;
    logic signed [XY_W-1:0] ya;
    logic signed [Z_W-1:0]  za;
    logic signed [XY_W-1:0] xb;
    logic signed [XY_W-1:0] yb;
    logic signed [Z_W-1:0]  zb;
  } cordic_slot_t;

endpackage
`default_nettype wire

@@ hw/rtl/euler_rotation_matrix_generator_core.sv @@
// euler_rotation_matrix_generator_core: top level, cordic pipeline, products, rounding
// depends on ermg_pkg
`default_nettype none
// Takes a rotation order (op) and two binary angles and returns all nine elements of
// the 3x3 frame rotation matrix as signed Q1.14 in one output beat. One beat is accepted
// every cycle unless stalled; its stages are: fold stage, one register per CORDIC
// stage, product stage, rounding stage, cutoff/output stage. The whole pipeline advances
// only when the output register is free or being taken, so a stall holds every stage.
// zero_cutoff forces elements whose magnitude is below it to zero; write it while idle.
module euler_rotation_matrix_generator_core #(
  parameter int ANGLE_BITS        = ermg_pkg::ANGLE_BITS_DEF,
  parameter int ELEMENT_FRAC_BITS = ermg_pkg::ELEMENT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES     = ermg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          op,
  input  wire logic signed [15:0]  angle_a,
  input  wire logic signed [15:0]  angle_b,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       m00,
  output logic signed [15:0]       m01,
  output logic signed [15:0]       m02,
  output logic signed [15:0]       m10,
  output logic signed [15:0]       m11,
  output logic signed [15:0]       m12,
  output logic signed [15:0]       m20,
  output logic signed [15:0]       m21,
  output logic signed [15:0]       m22
);
  localparam int XY_W = ermg_pkg::XY_W;
  localparam int Z_W  = ermg_pkg::Z_W;
  localparam int NST  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int F    = ELEMENT_FRAC_BITS;
  localparam int SH   = 60 - F;
  localparam int PW   = 2 * XY_W;

  logic [7:0] zero_cutoff;
  logic       adv;

  // pipeline advances when output is free or taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // cutoff register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_cutoff <= 8'd1;
    end else if (cfg_we) begin
      zero_cutoff <= cfg_wdata;
    end
  end

  // angle to 32-bit phase
  function automatic logic [31:0] to_phase(input logic signed [15:0] a);
    logic [31:0] v;
    v = 32'(signed'(a));
    return v << (32 - ANGLE_BITS);
  endfunction

  // fold phase into [-pi/2, pi/2]
  function automatic logic [Z_W:0] fold(input logic [31:0] p);
    logic signed [Z_W-1:0] z;
    logic                  fl;
    z  = Z_W'(signed'(p));
    fl = 1'b0;
    if (z > 34'sd1073741824) begin
      z  = z - 34'sd2147483648;
      fl = 1'b1;
    end else if (z < -34'sd1073741824) begin
      z  = z + 34'sd2147483648;
      fl = 1'b1;
    end
    return {fl, z};
  endfunction

  ermg_pkg::cordic_slot_t pipe [NST+1];

  // fold stage
  logic [31:0]  pa, pb;
  logic [Z_W:0] fa, fb;
  always_comb begin
    pa = to_phase(angle_a);
    pb = to_phase(angle_b);
    if (op == ermg_pkg::OP_ZY) begin
      pa = 32'd0 - pa;
      pb = 32'd0 - pb;
    end
    fa = fold(pa);
    fb = fold(pb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].vld <= 1'b0;
    end else if (adv) begin
      pipe[0].vld <= in_valid;
    end
    if (adv) begin
      pipe[0].op     <= op;
      pipe[0].flip_a <= fa[Z_W];
      pipe[0].flip_b <= fb[Z_W];
      pipe[0].za     <= fa[Z_W-1:0];
      pipe[0].zb     <= fb[Z_W-1:0];
      pipe[0].xa     <= ermg_pkg::CORDIC_GAIN_Q30;
      pipe[0].xb     <= ermg_pkg::CORDIC_GAIN_Q30;
      pipe[0].ya     <= '0;
      pipe[0].yb     <= '0;
    end
  end

  // one register per cordic micro-rotation, both angles side by side
  for (genvar i = 0; i < NST; i++) begin : g_cordic
    ermg_pkg::cordic_slot_t s, n;
    assign s = pipe[i];
    always_comb begin
      n = s;
      if (!s.za[Z_W-1]) begin
        n.xa = s.xa - (s.ya >>> i);
        n.ya = s.ya + (s.xa >>> i);
        n.za = s.za - ermg_pkg::atan_tab(i);
      end else begin
        n.xa = s.xa + (s.ya >>> i);
        n.ya = s.ya - (s.xa >>> i);
        n.za = s.za + ermg_pkg::atan_tab(i);
      end
      if (!s.zb[Z_W-1]) begin
        n.xb = s.xb - (s.yb >>> i);
        n.yb = s.yb + (s.xb >>> i);
        n.zb = s.zb - ermg_pkg::atan_tab(i);
      end else begin
        n.xb = s.xb + (s.yb >>> i);
        n.yb = s.yb - (s.xb >>> i);
        n.zb = s.zb + ermg_pkg::atan_tab(i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].vld <= 1'b0;
      end else if (adv) begin
        pipe[i+1].vld <= s.vld;
      end
      if (adv) begin
        pipe[i+1].op     <= n.op;
        pipe[i+1].flip_a <= n.flip_a;
        pipe[i+1].flip_b <= n.flip_b;
        pipe[i+1].xa     <= n.xa;
        pipe[i+1].ya     <= n.ya;
        pipe[i+1].za     <= n.za;
        pipe[i+1].xb     <= n.xb;
        pipe[i+1].yb     <= n.yb;
        pipe[i+1].zb     <= n.zb;
      end
    end
  end

  // product stage: apply quadrant flip and form Q60 elements
  ermg_pkg::cordic_slot_t last;
  logic signed [XY_W-1:0] sa, ca, sb, cb;
  logic signed [PW-1:0]   u60;
  logic signed [PW-1:0]   p [9];
  logic signed [PW-1:0]   q [9];
  assign last = pipe[NST];
  assign u60  = PW'(64'sd1 <<< 60);
  always_comb begin
    sa = last.flip_a ? -last.ya : last.ya;
    ca = last.flip_a ? -last.xa : last.xa;
    sb = last.flip_b ? -last.yb : last.yb;
    cb = last.flip_b ? -last.xb : last.xb;
    for (int k = 0; k < 9; k++) begin
      p[k] = (k % 4 == 0) ? u60 : '0;
      q[k] = '0;
    end
    case (last.op)
      ermg_pkg::OP_X: begin
        p[4] = PW'(ca) <<< 30; p[5] = PW'(sa) <<< 30;
        p[7] = -(PW'(sa) <<< 30); p[8] = PW'(ca) <<< 30;
      end
      ermg_pkg::OP_Y: begin
        p[0] = PW'(ca) <<< 30; p[2] = PW'(sa) <<< 30;
        p[6] = -(PW'(sa) <<< 30); p[8] = PW'(ca) <<< 30;
      end
      ermg_pkg::OP_Z: begin
        p[0] = PW'(ca) <<< 30; p[1] = PW'(sa) <<< 30;
        p[3] = -(PW'(sa) <<< 30); p[4] = PW'(ca) <<< 30;
      end
      ermg_pkg::OP_XZ: begin
        p[0] = PW'(ca) <<< 30; p[1] = PW'(sa) * PW'(cb); p[2] = PW'(sa) * PW'(sb);
        p[3] = -(PW'(sa) <<< 30); p[4] = PW'(ca) * PW'(cb); p[5] = PW'(ca) * PW'(sb);
        p[6] = '0; p[7] = -(PW'(sb) <<< 30); p[8] = PW'(cb) <<< 30;
      end
      ermg_pkg::OP_YX, ermg_pkg::OP_ZY: begin
        q[0] = PW'(cb) <<< 30; q[1] = '0; q[2] = PW'(sb) <<< 30;
        q[3] = -(PW'(sb) * PW'(sa)); q[4] = PW'(ca) <<< 30; q[5] = PW'(cb) * PW'(sa);
        q[6] = -(PW'(sb) * PW'(ca)); q[7] = -(PW'(sa) <<< 30); q[8] = PW'(cb) * PW'(ca);
        if (last.op == ermg_pkg::OP_YX) begin
          for (int k = 0; k < 9; k++) p[k] = q[k];
        end else begin
          for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
              p[r*3+c] = q[((r+2)%3)*3 + (c+2)%3];
        end
      end
      default: begin
      end
    endcase
  end

  logic                 prod_vld;
  logic signed [PW-1:0] prod [9];
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (adv) begin
      prod_vld <= last.vld;
    end
    if (adv) begin
      for (int k = 0; k < 9; k++) prod[k] <= p[k];
    end
  end

  // rounding and clamp stage
  logic                     rnd_vld;
  logic signed [F+1:0]      rnd [9];
  logic signed [PW-1:0]     t [9];
  logic signed [F+1:0]      tc [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      t[k] = (prod[k] + (PW'(1) <<< (SH-1))) >>> SH;
      if (t[k] > PW'(1 <<< F))       tc[k] = (F+2)'(1 <<< F);
      else if (t[k] < -PW'(1 <<< F)) tc[k] = -(F+2)'(1 <<< F);
      else                           tc[k] = t[k][F+1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_vld <= 1'b0;
    end else if (adv) begin
      rnd_vld <= prod_vld;
    end
    if (adv) begin
      for (int k = 0; k < 9; k++) rnd[k] <= tc[k];
    end
  end

  // cutoff and output register
  logic signed [15:0] o [9];
  logic        [F+1:0] mag [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mag[k] = rnd[k][F+1] ? (F+2)'(-rnd[k]) : rnd[k];
      o[k]   = ((F+2 > 8 ? mag[k] : mag[k]) < (F+2)'(zero_cutoff)) ? 16'sd0
               : 16'(rnd[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rnd_vld;
    end
    if (adv) begin
      m00 <= o[0]; m01 <= o[1]; m02 <= o[2];
      m10 <= o[3]; m11 <= o[4]; m12 <= o[5];
      m20 <= o[6]; m21 <= o[7]; m22 <= o[8];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ermg_checker.sv @@
// ermg_checker: port-level assertions for the euler rotation matrix generator core
// depends on euler_rotation_matrix_generator_core (bound below)
`default_nettype none
module ermg_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [15:0] m00,
  input wire logic signed [15:0] m11,
  input wire logic signed [15:0] m22
);
  // a held output beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m11) && $stable(m22))
    else $error("output beat changed under stall");
  // input is stalled exactly when a held output beat blocks the pipe
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  // m00 and m11 never exceed one in magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384 &&
                   m11 <= 16'sd16384 && m11 >= -16'sd16384))
    else $error("element out of range");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind euler_rotation_matrix_generator_core ermg_checker u_ermg_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .m00(m00), .m11(m11), .m22(m22)
);
`default_nettype wire

@@ tb/testbench.sv @@
// testbench for euler_rotation_matrix_generator_core: directed and random angle beats
// checked against an in-bench cordic/rounding predictor; depends on ermg_pkg and the core
`timescale 1ns / 1ps
module testbench;

  localparam int FRAC = 14;
  localparam int STAGES = 16;
  localparam int DRAIN = STAGES + 10;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic signed [15:0] angle_a = '0;
  logic signed [15:0] angle_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t expected_mats[$];
  logic [7:0] cutoff;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  euler_rotation_matrix_generator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .angle_a(angle_a), .angle_b(angle_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

  always #10 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint t [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861};
    return t[i];
  endfunction

  // rotation-mode cordic on a 32-bit phase, q30 out
  task automatic cordic_sincos(input logic [31:0] phase, output longint sn,
                               output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = phase;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z = z - atan_step(i);
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z = z + atan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = y;
    cs = x;
  endtask

  // q60 product to clamped, cut-off q1.14 element
  function automatic logic signed [15:0] round_elem(longint q60);
    longint e, mag;
    e = (q60 + (64'sd1 <<< (59 - FRAC))) >>> (60 - FRAC);
    if (e > (1 << FRAC)) e = 1 << FRAC;
    if (e < -(1 << FRAC)) e = -(1 << FRAC);
    mag = e < 0 ? -e : e;
    if (mag < cutoff) e = 0;
    return e[15:0];
  endfunction

  task automatic predict_matrix(input logic [2:0] code, input logic signed [15:0] a,
                                input logic signed [15:0] b, output matrix_t res);
    longint u, sa, ca, sb, cb;
    longint q [9];
    longint p [9];
    logic [31:0] pa, pb;
    u = 64'sd1 <<< 30;
    pa = {a, 16'h0};
    pb = {b, 16'h0};
    for (int k = 0; k < 9; k++) q[k] = (k % 4 == 0) ? u * u : 0;
    if (code == ermg_pkg::OP_ZY) begin
      pa = -pa;
      pb = -pb;
    end
    cordic_sincos(pa, sa, ca);
    cordic_sincos(pb, sb, cb);
    case (code)
      ermg_pkg::OP_X: begin
        q[4] = ca * u; q[5] = sa * u; q[7] = -sa * u; q[8] = ca * u;
      end
      ermg_pkg::OP_Y: begin
        q[0] = ca * u; q[2] = sa * u; q[6] = -sa * u; q[8] = ca * u;
      end
      ermg_pkg::OP_Z: begin
        q[0] = ca * u; q[1] = sa * u; q[3] = -sa * u; q[4] = ca * u;
      end
      ermg_pkg::OP_XZ: begin
        q[0] = ca * u; q[1] = sa * cb; q[2] = sa * sb;
        q[3] = -sa * u; q[4] = ca * cb; q[5] = ca * sb;
        q[6] = 0; q[7] = -sb * u; q[8] = cb * u;
      end
      ermg_pkg::OP_YX, ermg_pkg::OP_ZY: begin
        p[0] = cb * u; p[1] = 0; p[2] = sb * u;
        p[3] = -sb * sa; p[4] = ca * u; p[5] = cb * sa;
        p[6] = -sb * ca; p[7] = -sa * u; p[8] = cb * ca;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            q[r*3+c] = (code == ermg_pkg::OP_YX) ? p[r*3+c]
                                                 : p[((r+2)%3)*3 + (c+2)%3];
      end
      default: ;
    endcase
    for (int k = 0; k < 9; k++) res.m[k] = round_elem(q[k]);
  endtask

  // one input beat, with random idle gaps; valid stays up until the next beat or idle
  task automatic send_beat(input logic [2:0] code, input logic signed [15:0] a,
                           input logic signed [15:0] b);
    matrix_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    angle_a <= a;
    angle_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matrix(code, a, b, res);
    expected_mats.push_back(res);
    @(negedge clk);
  endtask

  // receiver stall
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // result checker
  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    if (!rst && out_valid && !out_stall) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_mats.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want.m[k]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     want.m[k], got[k]);
            errors++;
          end
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_mats.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic [7:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cutoff = v;
  endtask

  // extremes of angles, every op, unused codes, ignored second angle
  task automatic test_directed();
    logic signed [15:0] ang [6] = '{16'sh0000, 16'sh7fff, -16'sh8000,
                                    16'sh4000, -16'sh4000, 16'sh2000};
    for (int c = 0; c < 8; c++)
      send_beat(c[2:0], ang[c % 6], ang[(c + 1) % 6]);
    send_beat(ermg_pkg::OP_X, 16'sh1234, 16'sh7fff);
    send_beat(ermg_pkg::OP_X, 16'sh1234, -16'sh8000);
    send_beat(ermg_pkg::OP_YX, -16'sh8000, 16'sh7fff);
    send_beat(ermg_pkg::OP_ZY, 16'sh7fff, -16'sh8000);
    send_beat(ermg_pkg::OP_XZ, 16'sh4000, 16'sh4000);
    send_beat(ermg_pkg::OP_ZY, -16'sh4000, 16'sh2000);
    send_beat(ermg_pkg::OP_Z, 16'shffff, 16'sh0);
    send_beat(ermg_pkg::OP_Y, 16'sh0001, 16'shffff);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_beat(3'((($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5))),
                16'($urandom), 16'($urandom));
  endtask

  initial begin
    cutoff = 8'd1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    write_cutoff(8'd0);
    test_directed();
    write_cutoff(8'd255);
    test_directed();
    test_random(100);
    write_cutoff(8'd0);
    test_random(200);
    send_idle_pct = 54;
    write_cutoff(8'd17);
    test_random(200);
    send_idle_pct = 0;
    stall_pct = 54;
    write_cutoff(8'd128);
    test_random(200);
    send_idle_pct = 27;
    stall_pct = 27;
    write_cutoff(8'd1);
    test_random(200);
    send_idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
